// ----- hdl/wplb_pkg.sv -----
// -----------------------------------------------------------------------------
// wplb_pkg
// Shared types, codes and arithmetic helpers of the watermark luma boost unit.
// -----------------------------------------------------------------------------
`default_nettype none

package wplb_pkg;

    localparam int PIX_W   = 8;
    localparam int U_W     = 24;
    localparam int V_W     = 25;
    localparam int PROD_W  = 41;
    localparam int SUM_W   = 44;
    localparam int CFG_IDX_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_BOOST   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_BOOST = 8'd1;

    localparam logic [PIX_W-1:0] EDGE_BOOST_RST   = 8'd12;
    localparam logic [PIX_W-1:0] SMOOTH_BOOST_RST = 8'd5;

    // Q16 color coefficients
    localparam logic signed [V_W-1:0]    C_UR = 25'sd9642;
    localparam logic signed [V_W-1:0]    C_UG = 25'sd18931;
    localparam logic signed [V_W-1:0]    C_UB = 25'sd28574;
    localparam logic signed [V_W-1:0]    C_VR = 25'sd40305;
    localparam logic signed [V_W-1:0]    C_VG = 25'sd33750;
    localparam logic signed [V_W-1:0]    C_VB = 25'sd6554;
    localparam logic signed [PROD_W-1:0] C_RV = 41'sd74700;
    localparam logic signed [PROD_W-1:0] C_GU = 41'sd25864;
    localparam logic signed [PROD_W-1:0] C_GV = 41'sd38050;
    localparam logic signed [PROD_W-1:0] C_BU = 41'sd133176;

    typedef struct packed {
        logic [PIX_W-1:0] edge_boost;
        logic [PIX_W-1:0] smooth_boost;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]      red;
        logic [PIX_W-1:0]      green;
        logic [PIX_W-1:0]      blue;
        logic [PIX_W-1:0]      luma;
        logic                  edge_flag;
        logic                  mark_bit;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]      red;
        logic [PIX_W-1:0]      green;
        logic [PIX_W-1:0]      blue;
        logic [PIX_W-1:0]      luma;
        logic                  mark_bit;
        logic signed [U_W-1:0] u;
        logic signed [V_W-1:0] v;
    } chroma_t;

    typedef struct packed {
        logic [PIX_W-1:0]         red;
        logic [PIX_W-1:0]         green;
        logic [PIX_W-1:0]         blue;
        logic [PIX_W-1:0]         luma;
        logic                     mark_bit;
        logic signed [PROD_W-1:0] p_rv;
        logic signed [PROD_W-1:0] p_gu;
        logic signed [PROD_W-1:0] p_gv;
        logic signed [PROD_W-1:0] p_bu;
    } prod_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    // Q32 sum to a pixel: negative gives 0, integer part limited to 255
    function automatic logic [PIX_W-1:0] clamp_q32(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] res;
        if (s[SUM_W-1]) begin
            res = '0;
        end else if (|s[SUM_W-2:32+PIX_W]) begin
            res = '1;
        end else begin
            res = s[32+PIX_W-1:32];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/wplb_cfg.sv -----
// -----------------------------------------------------------------------------
// wplb_cfg
// Boost register file written through the configuration channel.
// -----------------------------------------------------------------------------
`default_nettype none

module wplb_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wplb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wplb_pkg::PIX_W-1:0]     cfg_data,
    output wplb_pkg::cfg_t                      cfg
);

    logic [wplb_pkg::PIX_W-1:0] edge_boost_reg;
    logic [wplb_pkg::PIX_W-1:0] smooth_boost_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_boost_reg   <= wplb_pkg::EDGE_BOOST_RST;
            smooth_boost_reg <= wplb_pkg::SMOOTH_BOOST_RST;
        end else if (cfg_valid) begin
            // drop writes to unknown indexes
            unique case (cfg_index)
                wplb_pkg::REG_EDGE_BOOST:   edge_boost_reg   <= cfg_data;
                wplb_pkg::REG_SMOOTH_BOOST: smooth_boost_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.edge_boost   = edge_boost_reg;
    assign cfg.smooth_boost = smooth_boost_reg;

endmodule

`default_nettype wire

// ----- hdl/wplb_chroma.sv -----
// -----------------------------------------------------------------------------
// wplb_chroma
// Stage 1: boost and saturate luma, derive U and V from the original RGB.
// -----------------------------------------------------------------------------
`default_nettype none

module wplb_chroma (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire wplb_pkg::cfg_t   cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire wplb_pkg::pixel_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wplb_pkg::chroma_t     out_data
);

    logic                      valid_reg;
    wplb_pkg::chroma_t         data_reg;
    wplb_pkg::chroma_t         data_next;
    logic [wplb_pkg::PIX_W:0]  luma_sum;
    logic signed [wplb_pkg::V_W-1:0] rs, gs, bs, u_full;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        luma_sum = {1'b0, in_data.luma} + {1'b0, in_data.edge_flag ? cfg.edge_boost
                                                                   : cfg.smooth_boost};
        rs = $signed({{(wplb_pkg::V_W-wplb_pkg::PIX_W){1'b0}}, in_data.red});
        gs = $signed({{(wplb_pkg::V_W-wplb_pkg::PIX_W){1'b0}}, in_data.green});
        bs = $signed({{(wplb_pkg::V_W-wplb_pkg::PIX_W){1'b0}}, in_data.blue});
        u_full = wplb_pkg::C_UB * bs - wplb_pkg::C_UR * rs - wplb_pkg::C_UG * gs;

        data_next.red      = in_data.red;
        data_next.green    = in_data.green;
        data_next.blue     = in_data.blue;
        data_next.mark_bit = in_data.mark_bit;
        data_next.luma     = luma_sum[wplb_pkg::PIX_W] ? '1 : luma_sum[wplb_pkg::PIX_W-1:0];
        data_next.u        = u_full[wplb_pkg::U_W-1:0];
        data_next.v        = wplb_pkg::C_VR * rs - wplb_pkg::C_VG * gs - wplb_pkg::C_VB * bs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/wplb_mult.sv -----
// -----------------------------------------------------------------------------
// wplb_mult
// Stage 2: scale U and V by the RGB rebuild coefficients.
// -----------------------------------------------------------------------------
`default_nettype none

module wplb_mult (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wplb_pkg::chroma_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wplb_pkg::prod_t        out_data
);

    logic                                valid_reg;
    wplb_pkg::prod_t                     data_reg;
    wplb_pkg::prod_t                     data_next;
    logic signed [wplb_pkg::PROD_W-1:0]  u_ext, v_ext;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        u_ext = wplb_pkg::PROD_W'(in_data.u);
        v_ext = wplb_pkg::PROD_W'(in_data.v);

        data_next.red      = in_data.red;
        data_next.green    = in_data.green;
        data_next.blue     = in_data.blue;
        data_next.luma     = in_data.luma;
        data_next.mark_bit = in_data.mark_bit;
        data_next.p_rv     = wplb_pkg::C_RV * v_ext;
        data_next.p_gu     = wplb_pkg::C_GU * u_ext;
        data_next.p_gv     = wplb_pkg::C_GV * v_ext;
        data_next.p_bu     = wplb_pkg::C_BU * u_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/wplb_rebuild.sv -----
// -----------------------------------------------------------------------------
// wplb_rebuild
// Stage 3: add boosted luma, clamp each channel, select pass-through.
// -----------------------------------------------------------------------------
`default_nettype none

module wplb_rebuild (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire wplb_pkg::prod_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output wplb_pkg::rgb_t       out_data
);

    logic                               valid_reg;
    wplb_pkg::rgb_t                     data_reg;
    wplb_pkg::rgb_t                     data_next;
    logic signed [wplb_pkg::SUM_W-1:0]  yq, sum_r, sum_g, sum_b;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        yq    = $signed({{(wplb_pkg::SUM_W-32-wplb_pkg::PIX_W){1'b0}}, in_data.luma, 32'd0});
        sum_r = yq + wplb_pkg::SUM_W'(in_data.p_rv);
        sum_g = yq - wplb_pkg::SUM_W'(in_data.p_gu) - wplb_pkg::SUM_W'(in_data.p_gv);
        sum_b = yq + wplb_pkg::SUM_W'(in_data.p_bu);

        // unmarked pixels pass through untouched
        if (in_data.mark_bit) begin
            data_next.red   = wplb_pkg::clamp_q32(sum_r);
            data_next.green = wplb_pkg::clamp_q32(sum_g);
            data_next.blue  = wplb_pkg::clamp_q32(sum_b);
        end else begin
            data_next.red   = in_data.red;
            data_next.green = in_data.green;
            data_next.blue  = in_data.blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/watermark_pixel_luma_boost_unit.sv -----
// Throughput: one pixel per cycle unless m_tready stalls it; the three register stages
// (chroma, coefficient multiply, rebuild and clamp) each hold one word and advance
// independently, so a stalled output only holds the stages behind it.
// Reset: synchronous active-low aresetn empties the pipeline and loads
// edge_boost = 12, smooth_boost = 5.
// -----------------------------------------------------------------------------
// watermark_pixel_luma_boost_unit
// Per-pixel luma boost with RGB rebuild through U and V for watermark marks.
// -----------------------------------------------------------------------------
`default_nettype none

module watermark_pixel_luma_boost_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,  // in_red, in_green, in_blue, luma
    input  wire logic [1:0]                     s_tuser,  // edge_flag, mark_bit
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata,  // out_red, out_green, out_blue
    // configuration
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wplb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wplb_pkg::PIX_W-1:0]     cfg_data
);

    wplb_pkg::cfg_t    cfg;
    wplb_pkg::pixel_t  pix;
    wplb_pkg::chroma_t s1_data;
    wplb_pkg::prod_t   s2_data;
    wplb_pkg::rgb_t    s3_data;
    logic              s1_valid, s1_ready;
    logic              s2_valid, s2_ready;

    assign pix.red       = s_tdata[7:0];
    assign pix.green     = s_tdata[15:8];
    assign pix.blue      = s_tdata[23:16];
    assign pix.luma      = s_tdata[31:24];
    assign pix.edge_flag = s_tuser[0];
    assign pix.mark_bit  = s_tuser[1];

    wplb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wplb_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pix),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    wplb_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    wplb_rebuild u_rebuild (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (s3_data)
    );

    assign m_tdata = {s3_data.blue, s3_data.green, s3_data.red};

endmodule

`default_nettype wire

// ----- tb/sv/wplb_luma_boost_checker.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// wplb_luma_boost_checker
// Watches the pixel, result and configuration channels of the luma boost unit.
// Keeps its own copy of the boost registers, works out the rebuilt pixel for
// every accepted input word and compares each result word against the oldest
// expected pixel. Failures are counted and handed to the testbench top.
// -----------------------------------------------------------------------------

module wplb_luma_boost_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // in_red, in_green, in_blue, luma
    input  logic [1:0]                     s_tuser,   // edge_flag, mark_bit
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [23:0]                    m_tdata,   // out_red, out_green, out_blue
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wplb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wplb_pkg::PIX_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending_words
);

    // BT.601 style chroma coefficients, signed Q16
    localparam longint K_U_R = 9642;
    localparam longint K_U_G = 18931;
    localparam longint K_U_B = 28574;
    localparam longint K_V_R = 40305;
    localparam longint K_V_G = 33750;
    localparam longint K_V_B = 6554;
    localparam longint K_R_V = 74700;
    localparam longint K_G_U = 25864;
    localparam longint K_G_V = 38050;
    localparam longint K_B_U = 133176;

    wplb_pkg::rgb_t expected_rgb_q[$];
    wplb_pkg::cfg_t boost_regs;
    int             reported;

    // floor of a Q32 sum, negative to 0, integer part saturated at 255
    function automatic logic [wplb_pkg::PIX_W-1:0] q32_to_pixel(input longint s);
        longint whole;
        whole = s >>> 32;
        if (s < 0) return '0;
        if (whole > 255) return 8'd255;
        return whole[wplb_pkg::PIX_W-1:0];
    endfunction

    function automatic wplb_pkg::rgb_t rebuild_marked_pixel(input wplb_pkg::pixel_t px,
                                                            input wplb_pkg::cfg_t regs);
        wplb_pkg::rgb_t res;
        longint         r, g, b, u, v, y, yq;
        r = longint'(px.red);
        g = longint'(px.green);
        b = longint'(px.blue);
        if (!px.mark_bit) begin
            res.red   = px.red;
            res.green = px.green;
            res.blue  = px.blue;
            return res;
        end
        y = longint'(px.luma) + longint'(px.edge_flag ? regs.edge_boost : regs.smooth_boost);
        if (y > 255) y = 255;
        u  = -K_U_R * r - K_U_G * g + K_U_B * b;
        v  =  K_V_R * r - K_V_G * g - K_V_B * b;
        yq = y <<< 32;
        res.red   = q32_to_pixel(yq + K_R_V * v);
        res.green = q32_to_pixel(yq - K_G_U * u - K_G_V * v);
        res.blue  = q32_to_pixel(yq + K_B_U * u);
        return res;
    endfunction

    initial begin
        fail_count    = 0;
        pending_words = 0;
        reported      = 0;
    end

    always @(posedge aclk) begin : monitor
        wplb_pkg::pixel_t px;
        wplb_pkg::rgb_t   got;
        wplb_pkg::rgb_t   want;
        if (!aresetn) begin
            expected_rgb_q.delete();
            boost_regs.edge_boost   = wplb_pkg::EDGE_BOOST_RST;
            boost_regs.smooth_boost = wplb_pkg::SMOOTH_BOOST_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wplb_pkg::REG_EDGE_BOOST:   boost_regs.edge_boost   = cfg_data;
                    wplb_pkg::REG_SMOOTH_BOOST: boost_regs.smooth_boost = cfg_data;
                    default: ;  // unmapped index: drop the write
                endcase
            end
            if (s_tvalid && s_tready) begin
                px.red       = s_tdata[7:0];
                px.green     = s_tdata[15:8];
                px.blue      = s_tdata[23:16];
                px.luma      = s_tdata[31:24];
                px.edge_flag = s_tuser[0];
                px.mark_bit  = s_tuser[1];
                expected_rgb_q.push_back(rebuild_marked_pixel(px, boost_regs));
            end
            if (m_tvalid && m_tready) begin
                got.red   = m_tdata[7:0];
                got.green = m_tdata[15:8];
                got.blue  = m_tdata[23:16];
                if (expected_rgb_q.size() == 0) begin
                    fail_count++;
                    if (reported < 10) begin
                        reported++;
                        $display("%0t: result word with nothing expected: r=%0d g=%0d b=%0d",
                                 $realtime, got.red, got.green, got.blue);
                    end
                end else begin
                    want = expected_rgb_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        fail_count++;
                        if (reported < 10) begin
                            reported++;
                            $display({"%0t: pixel mismatch: expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
        end
        pending_words = expected_rgb_q.size();
    end

endmodule

// ----- tb/sv/watermark_pixel_luma_boost_unit_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// watermark_pixel_luma_boost_unit_tb
// Drives pixel words with random gaps and a randomly stalling result side
// through the luma boost unit. A directed set covers pass-through, saturation,
// zero boost and inconsistent luma; random phases follow under several boost
// settings written while the pipeline is empty. The checker does the compare.
// -----------------------------------------------------------------------------

module watermark_pixel_luma_boost_unit_tb;

    localparam int                             DRAIN_CYCLES  = 8;
    localparam int                             CYCLE_LIMIT   = 1000000;
    localparam int                             PHASE_PIXELS  = 300;
    localparam logic [wplb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED  = 8'hFF;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [23:0]                    m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [wplb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wplb_pkg::PIX_W-1:0]     cfg_data;

    int fail_count;
    int pending_words;
    int cycle_count;
    bit no_gaps;

    watermark_pixel_luma_boost_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wplb_luma_boost_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[watermark_pixel_luma_boost_unit] ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // result side: stretches of steady ready, short stalls, rare long stalls
    initial begin
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 9) < 3) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 120)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] y, input logic edge_flag, input logic mark_bit);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, b, g, r};
        s_tuser  <= {mark_bit, edge_flag};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the sender until every expected pixel has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [wplb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wplb_pkg::PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_boosts(input logic [wplb_pkg::PIX_W-1:0] edge_val,
                                input logic [wplb_pkg::PIX_W-1:0] smooth_val,
                                input bit junk_write);
        write_reg(wplb_pkg::REG_EDGE_BOOST, edge_val);
        write_reg(wplb_pkg::REG_SMOOTH_BOOST, smooth_val);
        if (junk_write)
            write_reg(wplb_pkg::CFG_IDX_W'($urandom_range(wplb_pkg::REG_SMOOTH_BOOST + 1, 255)),
                      wplb_pkg::PIX_W'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_boost();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_random_pixel();
        logic [7:0] r, g, b, y;
        int         approx;
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
        // half the time a luma that fits the RGB, else anything
        approx = (77 * int'(r) + 150 * int'(g) + 29 * int'(b)) >> 8;
        y = $urandom_range(0, 1) ? approx[7:0] : pick_channel();
        push_pixel(r, g, b, y, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        no_gaps   = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset boosts: pass-through, edge/flat, overflow, odd luma
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        push_pixel(8'd128, 8'd64,  8'd32,  8'd80,  1'b0, 1'b1);
        push_pixel(8'd128, 8'd64,  8'd32,  8'd80,  1'b1, 1'b1);
        push_pixel(8'd200, 8'd200, 8'd200, 8'd250, 1'b1, 1'b1);
        push_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1);
        push_pixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 1'b1);
        push_pixel(8'd0,   8'd255, 8'd0,   8'd150, 1'b1, 1'b1);
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        wait_drained();

        // zero boost still goes through the chroma rebuild
        write_boosts(8'd0, 8'd0, 1'b0);
        push_pixel(8'd90,  8'd150, 8'd210, 8'd140, 1'b1, 1'b1);
        push_pixel(8'd90,  8'd150, 8'd210, 8'd140, 1'b0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        wait_drained();

        // full boosts, plus a write to an unmapped index
        write_boosts(8'd255, 8'd255, 1'b0);
        write_reg(REG_UNMAPPED, 8'd0);
        cfg_valid <= 1'b0;
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1);
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1);
        push_pixel(8'd255, 8'd0,   8'd255, 8'd100, 1'b1, 1'b1);
        push_pixel(8'd12,  8'd34,  8'd56,  8'd1,   1'b0, 1'b1);
        push_pixel(8'd12,  8'd34,  8'd56,  8'd1,   1'b0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       write_boosts(8'd255, 8'd0, 1'b0);
                1:       write_boosts(8'd0, 8'd255, 1'b1);
                default: write_boosts(pick_boost(), pick_boost(), phase % 2 == 0);
            endcase
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                // back-to-back stretches now and then
                if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                push_random_pixel();
            end
            no_gaps = 1'b0;
            wait_drained();
        end

        if (fail_count == 0 && pending_words == 0) begin
            $display("[watermark_pixel_luma_boost_unit] OK");
        end else begin
            $display("[watermark_pixel_luma_boost_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/wplb_pkg.sv
hdl/wplb_cfg.sv
hdl/wplb_chroma.sv
hdl/wplb_mult.sv
hdl/wplb_rebuild.sv
hdl/watermark_pixel_luma_boost_unit.sv
tb/sv/wplb_luma_boost_checker.sv
tb/sv/watermark_pixel_luma_boost_unit_tb.sv
